### hw/rtl/osa_pkg.sv
package osa_pkg;

  // default sizes of the set
  localparam int DEPTH_DEF  = 64;
  localparam int ADDR_W_DEF = 48;

  // fixed field widths on the channels
  localparam int FUNC_W    = 3;
  localparam int KEY_W     = 48;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  // command codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  // one result
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] match_index;
    logic [KEY_W-1:0]     read_address;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_t;

  // result handed from the sequencer to the output stage
  typedef struct packed {
    logic valid;
    res_t res;
  } res_msg_t;

endpackage

### hw/rtl/osa_ifs.sv
// request channel
interface osa_req_if;
  import osa_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key_address;
  logic [POS_W-1:0]  position;

  modport source(output valid, func, key_address, position, input ready);
  modport sink(input valid, func, key_address, position, output ready);
endinterface

// result channel
interface osa_rsp_if;
  import osa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [IDX_OUT_W-1:0] match_index;
  logic [KEY_W-1:0]     read_address;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source(output valid, status, match_index, read_address, entry_count, input ready);
  modport sink(input valid, status, match_index, read_address, entry_count, output ready);
endinterface

### hw/rtl/osa_mem.sv
module osa_mem #(
  parameter int DEPTH = osa_pkg::DEPTH_DEF,
  parameter int WIDTH = osa_pkg::ADDR_W_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/osa_ctrl.sv
module osa_ctrl #(
  parameter int DEPTH      = osa_pkg::DEPTH_DEF,
  parameter int ADDR_WIDTH = osa_pkg::ADDR_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [osa_pkg::FUNC_W-1:0] func,
  input  logic [osa_pkg::KEY_W-1:0]  key_address,
  input  logic [osa_pkg::POS_W-1:0]  position,
  output osa_pkg::res_msg_t        res,
  input  logic                     res_take
);
  import osa_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]            state, state_next;
  logic [FUNC_W-1:0]     cmd, cmd_next;
  logic [ADDR_WIDTH-1:0] key, key_next;
  logic [IDX_W-1:0]      pos_idx, pos_idx_next;
  logic [IDX_W-1:0]      scan, scan_next;
  logic [IDX_W-1:0]      hit, hit_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  res_t                  res_q;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [ADDR_WIDTH-1:0] wdata;
  logic [IDX_W-1:0]      raddr;
  logic [ADDR_WIDTH-1:0] rdata;

  logic                  fin;
  logic [STATUS_W-1:0]   fin_status;
  logic [IDX_W-1:0]      fin_idx;
  logic [ADDR_WIDTH-1:0] fin_raddr;

  logic [ADDR_WIDTH-1:0] key_in;
  logic                  pos_ok;
  logic                  match;
  logic                  full;
  logic [CNT_W-1:0]      scan_n1;
  logic [CNT_W-1:0]      scan_n2;

  // entry storage
  osa_mem #(
    .DEPTH(DEPTH),
    .WIDTH(ADDR_WIDTH)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // shared compare and index arithmetic
  assign key_in  = ADDR_WIDTH'(key_address);
  assign pos_ok  = CW'(position) < CW'(cnt);
  assign match   = (rdata == key);
  assign full    = (cnt == CNT_W'(DEPTH));
  assign scan_n1 = CNT_W'(scan) + CNT_W'(1);
  assign scan_n2 = CNT_W'(scan) + CNT_W'(2);

  // sequencer
  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    key_next     = key;
    pos_idx_next = pos_idx;
    scan_next    = scan;
    hit_next     = hit;
    cnt_next     = cnt;
    we           = 1'b0;
    waddr        = IDX_W'(cnt);
    wdata        = key;
    raddr        = '0;
    fin          = 1'b0;
    fin_status   = ST_OK;
    fin_idx      = '0;
    fin_raddr    = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next = func;
          key_next = key_in;
          unique case (func)
            FN_INSERT, FN_DELETE, FN_LOOKUP: begin
              if (cnt != '0) begin
                raddr      = '0;
                scan_next  = '0;
                state_next = S_SCAN;
              end else begin
                fin = 1'b1;
                if (func == FN_INSERT) begin
                  // empty set: append at the first entry
                  we       = 1'b1;
                  waddr    = '0;
                  wdata    = key_in;
                  cnt_next = CNT_W'(1);
                end else begin
                  fin_status = ST_NOTFOUND;
                end
              end
            end
            FN_READ: begin
              if (pos_ok) begin
                raddr        = IDX_W'(position);
                pos_idx_next = IDX_W'(position);
                state_next   = S_READ;
              end else begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end
            end
            FN_CLEAR: begin
              fin      = 1'b1;
              cnt_next = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (match) begin
          unique case (cmd)
            FN_INSERT: begin
              fin        = 1'b1;
              fin_status = ST_DUP;
              fin_idx    = scan;
            end
            FN_DELETE: begin
              hit_next = scan;
              if (scan_n1 < cnt) begin
                // start closing the gap
                raddr      = IDX_W'(scan_n1);
                state_next = S_SHIFT;
              end else begin
                fin      = 1'b1;
                fin_idx  = scan;
                cnt_next = cnt - CNT_W'(1);
              end
            end
            default: begin
              fin     = 1'b1;
              fin_idx = scan;
            end
          endcase
        end else if (scan_n1 < cnt) begin
          raddr     = IDX_W'(scan_n1);
          scan_next = IDX_W'(scan_n1);
        end else begin
          // no match among the valid entries
          fin = 1'b1;
          if (cmd == FN_INSERT) begin
            if (full) begin
              fin_status = ST_FULL;
            end else begin
              we       = 1'b1;
              waddr    = IDX_W'(cnt);
              wdata    = key;
              fin_idx  = IDX_W'(cnt);
              cnt_next = cnt + CNT_W'(1);
            end
          end else begin
            fin_status = ST_NOTFOUND;
          end
        end
      end

      S_SHIFT: begin
        // move the entry above down by one place
        we    = 1'b1;
        waddr = scan;
        wdata = rdata;
        if (scan_n2 < cnt) begin
          raddr     = IDX_W'(scan_n2);
          scan_next = IDX_W'(scan_n1);
        end else begin
          fin      = 1'b1;
          fin_idx  = hit;
          cnt_next = cnt - CNT_W'(1);
        end
      end

      S_READ: begin
        fin       = 1'b1;
        fin_idx   = pos_idx;
        fin_raddr = rdata;
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_DONE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    key     <= key_next;
    pos_idx <= pos_idx_next;
    scan    <= scan_next;
    hit     <= hit_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin) begin
      res_q.status       <= fin_status;
      res_q.match_index  <= IDX_OUT_W'(fin_idx);
      res_q.read_address <= KEY_W'(fin_raddr);
      res_q.entry_count  <= CNT_OUT_W'(cnt_next);
    end
  end

  assign req_ready = (state == S_IDLE);
  assign res.valid = (state == S_DONE);
  assign res.res   = res_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNT_W'(scan) < cnt))
    else $error("scan index past valid entries");

  a_shift_delete: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (cmd == FN_DELETE && scan_n1 < cnt))
    else $error("shift outside a delete");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && func == FN_CLEAR) |=> (cnt == '0))
    else $error("clear left entries");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (res_q.entry_count == CNT_OUT_W'(cnt)))
    else $error("reported count differs from held count");
`endif

endmodule

### hw/rtl/ordered_address_set.sv
// Ordered address set: holds up to DEPTH distinct addresses in insertion order and
// answers insert, delete, lookup, read-by-index and clear requests, one result per
// request. Entries sit in a single-port-write, single-port-read memory that one
// comparator walks one entry per cycle, so the block takes one request at a time.
// Clear, unused codes, out-of-range reads and any request on an empty set finish
// straight from idle; an in-range read first reads the entry at that position.
// Insert, delete and lookup compare entries in order up to the match, or the whole
// count on a miss, and a delete then moves each later entry down one place to
// close the gap. The result sits in an output register, so the next request is
// taken while a finished result waits. The memory needs no clearing after reset.
module ordered_address_set #(
  parameter int DEPTH      = osa_pkg::DEPTH_DEF,
  parameter int ADDR_WIDTH = osa_pkg::ADDR_W_DEF
) (
  input logic         clk,
  input logic         rst,
  osa_req_if.sink     req,
  osa_rsp_if.source   rsp
);
  import osa_pkg::*;

  res_msg_t res;
  logic     take;
  logic     out_valid;
  res_t     out_res;

  // sequencer with entry storage
  osa_ctrl #(
    .DEPTH     (DEPTH),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .func       (req.func),
    .key_address(req.key_address),
    .position   (req.position),
    .res        (res),
    .res_take   (take)
  );

  // output slot is free when empty or being drained
  assign take = !out_valid || rsp.ready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (res.valid && take) begin
      out_res <= res.res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_res.status;
  assign rsp.match_index  = out_res.match_index;
  assign rsp.read_address = out_res.read_address;
  assign rsp.entry_count  = out_res.entry_count;

endmodule
